// ===== sv/pbrle_pkg.sv =====
// Shared types and constants for the PackBits run-length decoder.
package pbrle_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 8;
    localparam int SIZE_W  = 24;
    localparam int PROD_W  = 25;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] HDR_LITERAL_MAX = 8'd127;
    localparam logic [BYTE_W-1:0] HDR_NOOP        = 8'd128;
    localparam logic [8:0]        REPEAT_BASE     = 9'd257;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [COUNT_W-1:0] run_count;
        logic               strip_done;
    } token_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== sv/packbits_run_length_decoder.sv =====
// Top level of the PackBits run-length decoder: front end, token queue and output stage.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, in_byte, strip_start  | in
//  output   | out_valid, out_stall, out_byte, run_count,| out
//           | strip_done                                |
//  config   | cfg_valid, cfg_ready, cfg_data            | in
//
// One compressed byte is accepted per cycle while in_stall is low; a token is written into
// the queue at the edge that accepts its data byte and reaches the output port through the
// output register once the output side is free. Reset clears the decoder state, the strip
// size and the queue. in_stall rises only when the two-entry queue is full, so a
// stalled output side backs up into the queue first and a free-running output never
// slows the input. Configuration writes complete in the cycle they are offered.
module packbits_run_length_decoder import pbrle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               strip_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [COUNT_W-1:0] run_count,
    output logic               strip_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIZE_W-1:0]  cfg_data
);

    logic [SIZE_W-1:0] size_reg;
    logic              accept;
    logic              push;
    logic              pop;
    token_t            push_token;
    token_t            head_token;
    q_status_t         q_status;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_status.full;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= '0;
        else if (cfg_valid && cfg_ready)
            size_reg <= cfg_data;
    end

    pbrle_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .in_byte          (in_byte),
        .strip_start      (strip_start),
        .strip_byte_count (size_reg),
        .push             (push),
        .push_token       (push_token)
    );

    pbrle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .head_token (head_token),
        .status     (q_status)
    );

    pbrle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_token (head_token),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_count  (run_count),
        .strip_done (strip_done)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full))
        else $error("token pushed into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_count != '0 && run_count <= COUNT_W'(128)))
        else $error("run_count outside 1 to 128");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && (!out_valid || !out_stall)) |=> out_valid)
        else $error("queued token not moved to the output");

    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !pop)
        else $error("queue popped while output transaction is held");
`endif

endmodule

// ===== sv/pbrle_front.sv =====
// Front end: accepts compressed bytes, tracks the PackBits state and emits run tokens.
module pbrle_front import pbrle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              strip_start,
    input  logic [SIZE_W-1:0] strip_byte_count,
    output logic              push,
    output token_t            push_token
);

    phase_t              phase_reg, phase_next, phase_eff;
    logic [COUNT_W-1:0]  lit_reg, lit_next, lit_eff;
    logic [COUNT_W-1:0]  rep_reg, rep_next, rep_eff;
    logic [PROD_W-1:0]   prod_reg, prod_next, prod_eff;

    logic [COUNT_W-1:0]  add_amount;
    logic [PROD_W:0]     sum;
    logic [PROD_W-1:0]   prod_sat;
    logic                limit_before;
    logic                limit_after;
    logic [8:0]          rep_wide;
    logic [COUNT_W-1:0]  lit_dec;

    always_comb
    begin
        if (strip_start)
        begin
            phase_eff = PH_HEADER;
            lit_eff   = '0;
            rep_eff   = '0;
            prod_eff  = '0;
        end
        else
        begin
            phase_eff = phase_reg;
            lit_eff   = lit_reg;
            rep_eff   = rep_reg;
            prod_eff  = prod_reg;
        end
    end

    assign add_amount   = (phase_eff == PH_LITERAL) ? COUNT_W'(1) : rep_eff;
    assign sum          = {1'b0, prod_eff} + {{(PROD_W + 1 - COUNT_W){1'b0}}, add_amount};
    assign prod_sat     = sum[PROD_W] ? {PROD_W{1'b1}} : sum[PROD_W-1:0];
    assign limit_before = prod_eff >= {1'b0, strip_byte_count};
    assign limit_after  = prod_sat >= {1'b0, strip_byte_count};
    assign rep_wide     = REPEAT_BASE - {1'b0, in_byte};
    assign lit_dec      = lit_eff - COUNT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_eff)
                PH_HEADER:
                begin
                    if (limit_before)
                        phase_next = PH_DONE;
                    else if (in_byte <= HDR_LITERAL_MAX)
                        phase_next = PH_LITERAL;
                    else if (in_byte != HDR_NOOP)
                        phase_next = PH_REPEAT;
                    else
                        phase_next = PH_HEADER;
                end
                PH_LITERAL:
                begin
                    if (lit_dec == '0)
                        phase_next = limit_after ? PH_DONE : PH_HEADER;
                    else
                        phase_next = PH_LITERAL;
                end
                PH_REPEAT:
                    phase_next = limit_after ? PH_DONE : PH_HEADER;
                default:
                    phase_next = PH_DONE;
            endcase
        end
    end

    always_comb
    begin
        lit_next   = lit_reg;
        rep_next   = rep_reg;
        prod_next  = prod_reg;
        push       = 1'b0;
        push_token = '{out_byte: in_byte, run_count: add_amount, strip_done: limit_after};
        if (accept)
        begin
            lit_next  = lit_eff;
            rep_next  = rep_eff;
            prod_next = prod_eff;
            case (phase_eff)
                PH_HEADER:
                begin
                    if (!limit_before && in_byte <= HDR_LITERAL_MAX)
                        lit_next = in_byte + COUNT_W'(1);
                    else if (!limit_before && in_byte != HDR_NOOP)
                        rep_next = rep_wide[COUNT_W-1:0];
                end
                PH_LITERAL:
                begin
                    push      = 1'b1;
                    prod_next = prod_sat;
                    lit_next  = lit_dec;
                end
                PH_REPEAT:
                begin
                    push      = 1'b1;
                    prod_next = prod_sat;
                    rep_next  = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lit_reg   <= '0;
            rep_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            rep_reg   <= rep_next;
            prod_reg  <= prod_next;
        end
    end

endmodule

// ===== sv/pbrle_queue.sv =====
// Short token queue between the decoding front end and the output stage.
module pbrle_queue import pbrle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  token_t    push_token,
    input  logic      pop,
    output token_t    head_token,
    output q_status_t status
);

    token_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_token   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/pbrle_back.sv =====
// Output stage: takes tokens from the queue and holds each until the output transaction completes.
module pbrle_back import pbrle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_status_t         q_status,
    input  token_t            head_token,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic [COUNT_W-1:0] run_count,
    output logic              strip_done
);

    logic   valid_reg, valid_next;
    token_t token_reg;

    assign pop        = !q_status.empty && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            token_reg <= head_token;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = token_reg.out_byte;
    assign run_count  = token_reg.run_count;
    assign strip_done = token_reg.strip_done;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the PackBits run-length decoder with its own token predictor.
module tb;
    import pbrle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } strip_byte_t;

    localparam logic [PROD_W-1:0] PRODUCED_SAT = '1;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 125;
    localparam int PRESSURE_PH = 5;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  in_byte = '0;
    logic               strip_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] run_count;
    logic               strip_done;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data = '0;

    strip_byte_t byte_feed[$];
    strip_byte_t next_byte;
    token_t      expected_tokens[$];

    phase_t             dec_phase = PH_HEADER;
    logic [COUNT_W-1:0] literals_left = '0;
    logic [COUNT_W-1:0] repeat_count = '0;
    logic [PROD_W-1:0]  produced = '0;
    logic [SIZE_W-1:0]  strip_size = '0;

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    logic hold_off = 1'b0;
    logic pressure_go = 1'b0;
    logic byte_taken = 1'b0;
    int  bytes_sent = 0;
    int  bytes_accepted = 0;
    int  tokens_checked = 0;
    int  done_tokens = 0;
    int  size_writes = 0;
    int  err_count = 0;

    packbits_run_length_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .strip_start (strip_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_count   (run_count),
        .strip_done  (strip_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic add_produced(input logic [PROD_W-1:0] n);
        logic [PROD_W:0] sum;
        sum = {1'b0, produced} + {1'b0, n};
        produced = (sum > {1'b0, PRODUCED_SAT}) ? PRODUCED_SAT : sum[PROD_W-1:0];
    endtask

    task automatic decode_packbits_byte(input logic [BYTE_W-1:0] b, input logic start);
        token_t tok;
        if (start)
        begin
            dec_phase = PH_HEADER;
            literals_left = '0;
            repeat_count = '0;
            produced = '0;
        end
        case (dec_phase)
            PH_HEADER:
            begin
                if (produced >= strip_size)
                    dec_phase = PH_DONE;
                else if (b <= HDR_LITERAL_MAX)
                begin
                    literals_left = b + 8'd1;
                    dec_phase = PH_LITERAL;
                end
                else if (b != HDR_NOOP)
                begin
                    repeat_count = 8'(REPEAT_BASE - {1'b0, b});
                    dec_phase = PH_REPEAT;
                end
            end
            PH_LITERAL:
            begin
                add_produced(PROD_W'(1));
                tok.out_byte = b;
                tok.run_count = 8'd1;
                tok.strip_done = (produced >= strip_size);
                expected_tokens = {expected_tokens, tok};
                literals_left = literals_left - 8'd1;
                if (literals_left == 0)
                    dec_phase = tok.strip_done ? PH_DONE : PH_HEADER;
            end
            PH_REPEAT:
            begin
                add_produced(PROD_W'(repeat_count));
                tok.out_byte = b;
                tok.run_count = repeat_count;
                tok.strip_done = (produced >= strip_size);
                expected_tokens = {expected_tokens, tok};
                repeat_count = '0;
                dec_phase = tok.strip_done ? PH_DONE : PH_HEADER;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_token();
        token_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("unexpected token byte %02h count %0d done %0b",
                                      out_byte, run_count, strip_done));
            return;
        end
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (want.strip_done)
            done_tokens++;
        if (out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.out_byte));
        if (run_count !== want.run_count)
            report_mismatch($sformatf("run_count %0d, expected %0d", run_count, want.run_count));
        if (strip_done !== want.strip_done)
            report_mismatch($sformatf("strip_done %0b, expected %0b",
                                      strip_done, want.strip_done));
    endtask

    // Input driver: a new byte is offered only once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || byte_taken)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = byte_feed.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= next_byte.data;
                    strip_start <= next_byte.start;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Monitor: predicts on every accepted byte and checks every accepted token.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            byte_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                decode_packbits_byte(in_byte, strip_start);
                bytes_accepted++;
            end
            if (out_valid && !out_stall)
                check_token();
        end
    end

    // The receiver holds off for a long stretch so the block backs up and stalls its input.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2_400_000;
        $display("tb: failure");
        $finish;
    end

    task automatic feed(input logic [BYTE_W-1:0] b, input logic s);
        strip_byte_t item;
        item.data = b;
        item.start = s;
        byte_feed = {byte_feed, item};
        bytes_sent++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (bytes_accepted != bytes_sent || expected_tokens.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_strip_size(input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        strip_size = value;
        size_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic gen_strip();
        int n;
        int r;
        int len;
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
                feed(8'(len - 1), k == 0);
                if ($urandom_range(19) == 0)
                    len = $urandom_range(0, len - 1);
                repeat (len) feed(8'($urandom), 1'b0);
            end
            else if (r < 90)
            begin
                len = $urandom_range(2, 128);
                feed(8'(REPEAT_BASE - 9'(len)), k == 0);
                feed(8'($urandom), 1'b0);
            end
            else if (r < 95)
                feed(HDR_NOOP, k == 0);
            else
                feed(8'($urandom), (k == 0) || ($urandom_range(7) == 0));
        end
    endtask

    initial
    begin
        int first;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A zero strip size ignores the whole strip.
        write_strip_size(24'd0);
        feed(8'h00, 1'b1);
        feed(8'h55, 1'b0);
        drain();

        // No-op, literals, short repeat, a literal packet crossing the limit, ignored bytes
        // after done, the longest repeat and a strip start that cuts a literal packet short.
        write_strip_size(24'd5);
        feed(HDR_NOOP, 1'b1);
        feed(8'h00, 1'b0);
        feed(8'hFF, 1'b0);
        feed(8'hFF, 1'b0);
        feed(8'h00, 1'b0);
        feed(8'h02, 1'b0);
        feed(8'h12, 1'b0);
        feed(8'h34, 1'b0);
        feed(8'h56, 1'b0);
        feed(8'h01, 1'b0);
        feed(8'h81, 1'b1);
        feed(8'hA5, 1'b0);
        feed(8'h7F, 1'b1);
        feed(8'h01, 1'b0);
        feed(8'h81, 1'b1);
        feed(8'h5A, 1'b0);
        drain();

        // Raising the size does not leave done; only a strip start does.
        write_strip_size(24'hFF_FFFF);
        feed(8'h00, 1'b0);
        feed(8'h81, 1'b1);
        feed(8'hC3, 1'b0);
        feed(8'h7F, 1'b0);
        feed(8'hEE, 1'b0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_strip_size(24'd1);
                1: write_strip_size(24'hFF_FFFF);
                default: write_strip_size(SIZE_W'($urandom_range(8, 500)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            if (p == PRESSURE_PH)
            begin
                send_idle_pct = 0;
                stall_pct = 0;
                pressure_go = 1'b1;
            end
            first = bytes_sent;
            while (bytes_sent - first < PHASE_BYTES)
                gen_strip();
            drain();
        end

        $display("tb: %0d compressed bytes decoded into %0d checked tokens, %0d at strip end",
                 bytes_accepted, tokens_checked, done_tokens);
        $display("tb: %0d strip size settings, sender and receiver idling varied, %0d errors",
                 size_writes, err_count);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
